// File: rtl/midi_cc_to_sysex_translator_macros.svh
// ----------------------------------------------------------------------------
// midi_cc_to_sysex_translator_macros
// assertion helpers used by the translator controller
// ----------------------------------------------------------------------------
`ifndef MIDI_CC_TO_SYSEX_TRANSLATOR_MACROS_SVH
`define MIDI_CC_TO_SYSEX_TRANSLATOR_MACROS_SVH

// same-cycle implication
`define MCST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcst same-cycle check failed");

// next-cycle implication
`define MCST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcst next-cycle check failed");

`endif

// File: rtl/mcst_pkg.sv
// ----------------------------------------------------------------------------
// mcst_pkg
// shared types and constants of the midi cc to sysex translator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcst_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int CH_W       = 4;
  localparam int NP_W       = 3;
  localparam int PG_W       = 3;
  localparam int CTL_W      = 8;
  localparam int MAP_CTL_W  = 7;
  localparam int BYTE_W     = 8;
  localparam int DIV_W      = 7;
  localparam int EIDX_W     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PAGES    = 2'd1;

  localparam logic [CH_W-1:0] CH_RESET = 4'd0;
  localparam logic [NP_W-1:0] NP_RESET = 3'd4;

  localparam logic [3:0]        CC_STATUS_HI = 4'hB;
  localparam logic [BYTE_W-1:0] SYX_START    = 8'hF0;
  localparam logic [BYTE_W-1:0] SYX_MFR_ID   = 8'h41;
  localparam logic [BYTE_W-1:0] SYX_MODEL_ID = 8'h36;
  localparam logic [BYTE_W-1:0] SYX_CMD      = 8'h24;
  localparam logic [BYTE_W-1:0] SYX_GROUP    = 8'h20;
  localparam logic [BYTE_W-1:0] SYX_SUBGROUP = 8'h01;
  localparam logic [BYTE_W-1:0] SYX_END      = 8'hF7;

  localparam logic [BYTE_W-1:0] ENTRY_NONE = 8'h00;
  localparam logic [BYTE_W-1:0] ENTRY_SAVE = 8'hFE;
  localparam logic [BYTE_W-1:0] ENTRY_PAGE = 8'hFF;

  localparam logic [EIDX_W-1:0] LAST_PASS = 4'd0;
  localparam logic [EIDX_W-1:0] LAST_CC   = 4'd2;
  localparam logic [EIDX_W-1:0] LAST_SYX  = 4'd9;

  typedef enum logic [1:0] {
    EK_PASS,
    EK_CC,
    EK_SYX
  } emit_kind_e;

  typedef struct packed {
    logic       clr_step;
    logic       tab_wr;
    logic       cap_byte;
    logic       load_ctl;
    logic       rd_entry;
    logic       latch_entry;
    logic       div_start;
    logic       div_step;
    logic       emit_start;
    emit_kind_e emit_kind;
    logic       emit_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_op;
    logic in_is_status;
    logic ent_page;
    logic ent_save;
    logic ent_none;
    logic div_done;
    logic out_free;
    logic emit_last;
  } dp_sts_t;

  // 127 / num_pages, a page count of zero counts as one
  function automatic logic [DIV_W-1:0] page_divisor(input logic [NP_W-1:0] np);
    logic [DIV_W-1:0] d;
    case (np)
      3'd2:    d = 7'd63;
      3'd3:    d = 7'd42;
      3'd4:    d = 7'd31;
      3'd5:    d = 7'd25;
      3'd6:    d = 7'd21;
      3'd7:    d = 7'd18;
      default: d = 7'd127;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/mcst_ram.sv
// ----------------------------------------------------------------------------
// mcst_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mcst_dp.sv
// ----------------------------------------------------------------------------
// mcst_dp
// translator datapath: config, map table, page divider, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcst_dp #(
  parameter int NUM_CONTROLLERS = 128,
  parameter int NUM_PAGE_SLOTS  = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mcst_pkg::dp_cmd_t                  cmd_i,
  output mcst_pkg::dp_sts_t                  sts_o,
  input  logic                               operation_i,
  input  logic [7:0]                         midi_byte_i,
  input  logic [mcst_pkg::MAP_CTL_W-1:0]     map_controller_i,
  input  logic [mcst_pkg::PG_W-1:0]          map_page_i,
  input  logic [7:0]                         map_entry_i,
  input  logic                               cfg_valid_i,
  input  logic [mcst_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mcst_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic [7:0]                         out_byte_o,
  output logic                               last_o
);

  import mcst_pkg::*;

  localparam int DEPTH = NUM_CONTROLLERS * NUM_PAGE_SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CH_W-1:0]   ch_q;
  logic [NP_W-1:0]   np_q;
  logic [AW-1:0]     clr_cnt_q;
  logic [BYTE_W-1:0] byte_q;
  logic [CTL_W-1:0]  ctl_q;
  logic [PG_W-1:0]   page_q;
  logic [BYTE_W-1:0] entry_q;
  logic [BYTE_W-1:0] rem_q;
  logic [PG_W-1:0]   quo_q;
  emit_kind_e        kind_q;
  logic [EIDX_W-1:0] idx_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;

  logic              map_ok;
  logic [AW-1:0]     map_addr;
  logic              ctl_ok;
  logic [AW-1:0]     rd_addr;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] entry;
  logic [DIV_W-1:0]  divisor;
  logic              div_done;
  logic [BYTE_W-1:0] status_byte;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;
  logic              out_free;

  assign status_byte = {CC_STATUS_HI, ch_q};

  assign map_ok   = (int'(map_controller_i) < NUM_CONTROLLERS) &&
                    (int'(map_page_i) < NUM_PAGE_SLOTS);
  assign map_addr = AW'(int'(map_controller_i) * NUM_PAGE_SLOTS + int'(map_page_i));
  assign ctl_ok   = int'(ctl_q) < NUM_CONTROLLERS;
  assign rd_addr  = AW'(int'(ctl_q) * NUM_PAGE_SLOTS + int'(page_q));

  assign ram_we    = cmd_i.clr_step || (cmd_i.tab_wr && map_ok);
  assign ram_waddr = cmd_i.clr_step ? clr_cnt_q : map_addr;
  assign ram_wdata = cmd_i.clr_step ? ENTRY_NONE : map_entry_i;

  mcst_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_entry),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign entry    = ctl_ok ? ram_rdata : ENTRY_NONE;
  assign divisor  = page_divisor(np_q);
  assign div_done = (rem_q < {1'b0, divisor}) || (quo_q == PG_W'(NUM_PAGE_SLOTS - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    emit_byte = byte_q;
    emit_last = 1'b0;
    case (kind_q)
      EK_PASS: begin
        emit_byte = byte_q;
        emit_last = (idx_q == LAST_PASS);
      end
      EK_CC: begin
        case (idx_q)
          4'd0:    emit_byte = status_byte;
          4'd1:    emit_byte = ctl_q;
          default: emit_byte = byte_q;
        endcase
        emit_last = (idx_q == LAST_CC);
      end
      EK_SYX: begin
        case (idx_q)
          4'd0:    emit_byte = SYX_START;
          4'd1:    emit_byte = SYX_MFR_ID;
          4'd2:    emit_byte = SYX_MODEL_ID;
          4'd3:    emit_byte = {4'h0, ch_q};
          4'd4:    emit_byte = SYX_CMD;
          4'd5:    emit_byte = SYX_GROUP;
          4'd6:    emit_byte = SYX_SUBGROUP;
          4'd7:    emit_byte = entry_q;
          4'd8:    emit_byte = byte_q;
          default: emit_byte = SYX_END;
        endcase
        emit_last = (idx_q == LAST_SYX);
      end
      default: begin
        emit_byte = byte_q;
        emit_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q        <= CH_RESET;
      np_q        <= NP_RESET;
      clr_cnt_q   <= '0;
      ctl_q       <= '0;
      page_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CFG_MIDI_CHANNEL) begin
        ch_q <= cfg_data_i[CH_W-1:0];
      end
      if (cfg_valid_i && cfg_index_i == CFG_NUM_PAGES) begin
        np_q <= cfg_data_i[NP_W-1:0];
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.load_ctl) begin
        ctl_q <= midi_byte_i;
      end
      if (cmd_i.div_step && div_done) begin
        page_q <= quo_q;
      end
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_byte) begin
      byte_q <= midi_byte_i;
    end
    if (cmd_i.latch_entry) begin
      entry_q <= entry;
    end
    if (cmd_i.div_start) begin
      rem_q <= byte_q;
      quo_q <= '0;
    end else if (cmd_i.div_step && !div_done) begin
      rem_q <= rem_q - {1'b0, divisor};
      quo_q <= quo_q + PG_W'(1);
    end
    if (cmd_i.emit_start) begin
      kind_q <= cmd_i.emit_kind;
      idx_q  <= '0;
    end else if (cmd_i.emit_load) begin
      idx_q <= idx_q + EIDX_W'(1);
    end
    if (cmd_i.emit_load) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  always_comb begin
    sts_o              = '0;
    sts_o.clr_last     = (clr_cnt_q == AW'(DEPTH - 1));
    sts_o.in_op        = operation_i;
    sts_o.in_is_status = (midi_byte_i == status_byte);
    sts_o.ent_page     = (entry == ENTRY_PAGE);
    sts_o.ent_save     = (entry == ENTRY_SAVE);
    sts_o.ent_none     = (entry == ENTRY_NONE);
    sts_o.div_done     = div_done;
    sts_o.out_free     = out_free;
    sts_o.emit_last    = emit_last;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

endmodule

// File: rtl/mcst_ctrl.sv
// ----------------------------------------------------------------------------
// mcst_ctrl
// translator controller: table clear, midi parse and output sequencing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "midi_cc_to_sysex_translator_macros.svh"

module mcst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output mcst_pkg::dp_cmd_t cmd_o,
  input  mcst_pkg::dp_sts_t sts_i
);

  import mcst_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_DIV,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    P_STATUS,
    P_CTRL,
    P_VALUE
  } parse_e;

  state_e state_q, state_d;
  parse_e parse_q, parse_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    parse_d = parse_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.in_op) begin
            cmd_o.tab_wr = 1'b1;
          end else begin
            cmd_o.cap_byte = 1'b1;
            case (parse_q)
              P_STATUS: begin
                if (sts_i.in_is_status) begin
                  parse_d = P_CTRL;
                end else begin
                  cmd_o.emit_start = 1'b1;
                  cmd_o.emit_kind  = EK_PASS;
                  state_d          = S_EMIT;
                end
              end
              P_CTRL: begin
                cmd_o.load_ctl = 1'b1;
                parse_d        = P_VALUE;
              end
              P_VALUE: begin
                cmd_o.rd_entry = 1'b1;
                parse_d        = P_STATUS;
                state_d        = S_LOOK;
              end
              default: begin
                parse_d = P_STATUS;
              end
            endcase
          end
        end
      end
      S_LOOK: begin
        cmd_o.latch_entry = 1'b1;
        if (sts_i.ent_page) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else if (sts_i.ent_save) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.emit_start = 1'b1;
          cmd_o.emit_kind  = sts_i.ent_none ? EK_CC : EK_SYX;
          state_d          = S_EMIT;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      parse_q <= P_STATUS;
    end else begin
      state_q <= state_d;
      parse_q <= parse_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  `MCST_ASSERT_NXT(a_clear_ends_idle, clk_i, rst_ni, state_q == S_CLEAR && sts_i.clr_last, state_q == S_IDLE)
  `MCST_ASSERT_IMP(a_load_into_free_reg, clk_i, rst_ni, cmd_o.emit_load, sts_i.out_free)
  `MCST_ASSERT_IMP(a_div_after_message, clk_i, rst_ni, state_q == S_DIV, parse_q == P_STATUS)

endmodule

// File: rtl/midi_cc_to_sysex_translator.sv
// ----------------------------------------------------------------------------
// midi_cc_to_sysex_translator
// forwards midi bytes and turns mapped control changes into parameter sysex
// ----------------------------------------------------------------------------
// After reset the map table is cleared, one entry a cycle, all
// NUM_CONTROLLERS * NUM_PAGE_SLOTS entries (1024 by default); no item is taken
// until then, configuration writes are. One item is worked on at a time: a
// table write, a held status or a controller byte is handled in the idle
// state, a forwarded byte gives one output byte, and a value byte reads the
// table and then gives 3 or 10 output bytes, does nothing for a save, or runs
// the divider for a page select (one subtract per cycle). Output stall adds
// to the emit phase. A waiting last byte does not block the next item.
`timescale 1ns / 1ps

module midi_cc_to_sysex_translator #(
  parameter int NUM_CONTROLLERS = 128,
  parameter int NUM_PAGE_SLOTS  = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            operation_i,
  input  logic [7:0]                      midi_byte_i,
  input  logic [mcst_pkg::MAP_CTL_W-1:0]  map_controller_i,
  input  logic [mcst_pkg::PG_W-1:0]       map_page_i,
  input  logic [7:0]                      map_entry_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out_byte_o,
  output logic                            last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mcst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mcst_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import mcst_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  mcst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  mcst_dp #(
    .NUM_CONTROLLERS (NUM_CONTROLLERS),
    .NUM_PAGE_SLOTS  (NUM_PAGE_SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (operation_i),
    .midi_byte_i      (midi_byte_i),
    .map_controller_i (map_controller_i),
    .map_page_i       (map_page_i),
    .map_entry_i      (map_entry_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o)
  );

endmodule

// File: bench/midi_cc_to_sysex_translator_tb.sv
// ----------------------------------------------------------------------------
// midi_cc_to_sysex_translator_tb
// Self-checking bench for the control-change to sysex translator. A
// scoreboard class tracks the channel, the page count, the parse position,
// the current page and the whole mapping table. It turns each accepted item
// into the output bytes it should cause, and checks each byte the block
// sends against the oldest one still due. A directed opening covers
// pass-through, re-sent control changes, sysex runs, page select with
// saturation, save, controllers beyond the table and table writes in the
// middle of a message. Random traffic then runs under several channel and
// page-count settings, with random gaps and output stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_cc_to_sysex_translator_tb;
  import mcst_pkg::*;

  localparam int MAP_DEPTH      = 128 * 8;
  localparam int PAGE_RANGE     = 127;
  localparam int PAGE_TOP       = 7;
  localparam int GAP_MAX        = 8;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 46;
  localparam int REPORT_MAX     = 10;

  localparam logic OP_MIDI      = 1'b0;
  localparam logic OP_MAP_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {
    PS_STATUS,
    PS_CTL,
    PS_VALUE,
    PS_SPARE
  } parse_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } tx_byte_t;

  class translation_board;
    logic [CH_W-1:0]   channel;
    logic [NP_W-1:0]   pages;
    parse_e            parse;
    logic [CTL_W-1:0]  held_ctl;
    logic [PG_W-1:0]   page;
    logic [BYTE_W-1:0] map_mem [MAP_DEPTH];
    tx_byte_t          due_bytes [$];
    int mismatches;
    int bytes_checked;
    int sysex_runs;
    int cc_runs;
    int page_selects;
    int saves;

    function new();
      channel  = CH_RESET;
      pages    = NP_RESET;
      parse    = PS_STATUS;
      held_ctl = '0;
      page     = '0;
      foreach (map_mem[i]) map_mem[i] = ENTRY_NONE;
      mismatches    = 0;
      bytes_checked = 0;
      sysex_runs    = 0;
      cc_runs       = 0;
      page_selects  = 0;
      saves         = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_MIDI_CHANNEL) channel = val[CH_W-1:0];
      else if (idx == CFG_NUM_PAGES) pages = val[NP_W-1:0];
    endfunction

    function void note_input(logic op, logic [BYTE_W-1:0] b, logic [MAP_CTL_W-1:0] ctl,
                             logic [PG_W-1:0] pg, logic [BYTE_W-1:0] ent);
      logic [BYTE_W-1:0] run [$];
      logic [BYTE_W-1:0] status;
      logic [BYTE_W-1:0] hit;
      int np;
      int div;
      int sel;
      status = {CC_STATUS_HI, channel};
      if (op == OP_MAP_WRITE) begin
        map_mem[{ctl, pg}] = ent;
        return;
      end
      case (parse)
        PS_STATUS: begin
          if (b == status) parse = PS_CTL;
          else run.push_back(b);
        end
        PS_CTL: begin
          held_ctl = b;
          parse    = PS_VALUE;
        end
        PS_VALUE: begin
          // controllers past the table read as unmapped
          hit   = held_ctl[7] ? ENTRY_NONE : map_mem[{held_ctl[6:0], page}];
          parse = PS_STATUS;
          if (hit == ENTRY_PAGE) begin
            np  = (pages == 0) ? 1 : int'(pages);
            div = PAGE_RANGE / np;
            sel = int'(b) / div;
            page = (sel > PAGE_TOP) ? PG_W'(PAGE_TOP) : sel[PG_W-1:0];
            page_selects++;
          end else if (hit == ENTRY_SAVE) begin
            saves++;
          end else if (hit != ENTRY_NONE) begin
            run = '{SYX_START, SYX_MFR_ID, SYX_MODEL_ID, {4'h0, channel}, SYX_CMD,
                    SYX_GROUP, SYX_SUBGROUP, hit, b, SYX_END};
            sysex_runs++;
          end else begin
            run = '{status, held_ctl, b};
            cc_runs++;
          end
        end
        default: parse = PS_STATUS;
      endcase
      foreach (run[i]) due_bytes.push_back(tx_byte_t'{data: run[i], last: (i == run.size() - 1)});
    endfunction

    function void check_byte(logic [BYTE_W-1:0] data, logic last);
      tx_byte_t want;
      bytes_checked++;
      if (due_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected output byte %02h last %0b", data, last);
        return;
      end
      want = due_bytes.pop_front();
      if (want.data !== data || want.last !== last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("output byte %0d: expected %02h last %0b, got %02h last %0b",
                   bytes_checked, want.data, want.last, data, last);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  operation_i = OP_MIDI;
  logic [7:0]            midi_byte_i = '0;
  logic [MAP_CTL_W-1:0]  map_controller_i = '0;
  logic [PG_W-1:0]       map_page_i = '0;
  logic [7:0]            map_entry_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [7:0]            out_byte_o;
  logic                  last_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  translation_board sb = new();
  bit no_idle = 1'b0;
  int items_sent = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  logic [CFG_DATA_W-1:0] phase_ch [NUM_PHASES] = '{4'd15, 4'd0, 4'd9, 4'd15, 4'd3, 4'd0, 4'd12, 4'd6};
  logic [CFG_DATA_W-1:0] phase_np [NUM_PHASES] = '{4'd1, 4'd7, 4'd0, 4'd2, 4'd5, 4'd6, 4'd3, 4'd12};

  midi_cc_to_sysex_translator u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .midi_byte_i      (midi_byte_i),
    .map_controller_i (map_controller_i),
    .map_page_i       (map_page_i),
    .map_entry_i      (map_entry_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  task automatic send_item(input logic op, input logic [7:0] b, input logic [MAP_CTL_W-1:0] ctl,
                           input logic [PG_W-1:0] pg, input logic [7:0] ent);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    midi_byte_i      <= b;
    map_controller_i <= ctl;
    map_page_i       <= pg;
    map_entry_i      <= ent;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op, b, ctl, pg, ent);
    items_sent++;
  endtask

  task automatic send_midi(input logic [7:0] b);
    send_item(OP_MIDI, b, MAP_CTL_W'($urandom), PG_W'($urandom), 8'($urandom));
  endtask

  task automatic send_map(input logic [MAP_CTL_W-1:0] ctl, input logic [PG_W-1:0] pg,
                          input logic [7:0] ent);
    send_item(OP_MAP_WRITE, 8'($urandom), ctl, pg, ent);
  endtask

  // mostly a small pool of controllers so that written entries get hit
  task automatic send_random_map();
    logic [MAP_CTL_W-1:0] ctl;
    logic [7:0] ent;
    ctl = ($urandom_range(0, 3) == 0) ? MAP_CTL_W'($urandom) : MAP_CTL_W'($urandom_range(0, 7));
    case ($urandom_range(0, 4))
      0:       ent = ENTRY_NONE;
      1:       ent = ENTRY_PAGE;
      2:       ent = ENTRY_SAVE;
      default: ent = 8'($urandom_range(1, 253));
    endcase
    send_map(ctl, PG_W'($urandom), ent);
  endtask

  task automatic drain(input int extra);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.due_bytes.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] ch, input logic [CFG_DATA_W-1:0] np);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{CFG_MIDI_CHANNEL, CFG_NUM_PAGES, CFG_SPARE_A, CFG_SPARE_B};
    val = '{ch, np, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.apply_reg(idx[i], val[i]);
    end
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // output side: random stall after each accepted byte
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        sb.check_byte(out_byte_o, last_o);
        hold = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      end
      out_stall_i <= (hold > 0);
      if (hold > 0) hold--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int k;
    int pick;
    bit paused;
    logic [7:0] st;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    program_regs(CFG_DATA_W'(CH_RESET), CFG_DATA_W'(NP_RESET));
    st = {CC_STATUS_HI, sb.channel};

    // pass-through, including another channel's control change
    send_midi(8'h00);
    send_midi(8'hFF);
    send_midi(8'h90);
    send_midi(st + 8'd1);
    // unmapped control change is re-sent
    send_midi(st);
    send_midi(8'h07);
    send_midi(8'h40);
    // mapped entry gives a sysex run
    send_map(7'h07, 3'd0, 8'h12);
    send_midi(st);
    send_midi(8'h07);
    send_midi(8'h7F);
    send_map(7'h10, 3'd0, ENTRY_PAGE);
    send_map(7'h10, 3'd4, ENTRY_PAGE);
    send_map(7'h7F, 3'd7, ENTRY_SAVE);
    // page select to page 4, then past the last page
    send_midi(st);
    send_midi(8'h10);
    send_midi(8'h7F);
    send_midi(st);
    send_midi(8'h10);
    send_midi(8'hFF);
    // save on the top page gives nothing
    send_midi(st);
    send_midi(8'h7F);
    send_midi(8'h00);
    // table write inside a message, controller byte beyond the table
    send_midi(st);
    send_map(7'h00, 3'd7, ENTRY_PAGE);
    send_midi(8'h85);
    send_midi(8'h90);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain(SETTLE_CYCLES);
      program_regs(phase_ch[p], phase_np[p]);
      st      = {CC_STATUS_HI, sb.channel};
      no_idle = (p % 3 == 2);
      paused  = 1'b0;
      k       = 0;
      while (k < PHASE_ITEMS) begin
        if (p == 1 && !paused && k >= PHASE_ITEMS / 2) begin
          drain(0);
          paused = 1'b1;
        end
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          send_random_map();
          k++;
        end else if (pick < 8) begin
          send_midi(st);
          if ($urandom_range(0, 7) == 0) begin
            send_random_map();
            k++;
          end
          send_midi(($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)));
          send_midi(8'($urandom));
          k += 3;
        end else begin
          send_midi(8'($urandom));
          k++;
        end
      end
    end

    drain(SETTLE_CYCLES);
    $display("%0d items under %0d register settings, %0d output bytes checked",
             items_sent, settings_used, sb.bytes_checked);
    $display("%0d sysex runs, %0d re-sent control changes, %0d page selects, %0d saves",
             sb.sysex_runs, sb.cc_runs, sb.page_selects, sb.saves);
    if (sb.mismatches == 0 && sb.due_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d expected bytes never sent",
               sb.mismatches, sb.due_bytes.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
